// File: rtl/interval_cover_count_tree_assert.svh
// Assertion macros used by the interval cover counter RTL.
// Each macro expands to one labeled concurrent assertion on i_clk, off in reset.
`ifndef INTERVAL_COVER_COUNT_TREE_ASSERT_SVH
`define INTERVAL_COVER_COUNT_TREE_ASSERT_SVH

// Same-cycle implication
`define ICCT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ICCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/icct_pkg.sv
// Package for the interval cover counter: request/result payloads, op codes,
// memory port control group. No dependencies.
`default_nettype none

package icct_pkg;

    localparam int FIELD_W = 10;
    localparam int OUT_W   = 16;
    localparam logic [OUT_W-1:0] OUT_MAX = 16'hFFFF;

    // Operation codes
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic [FIELD_W-1:0] range_low;
        logic [FIELD_W-1:0] range_high;
        logic [FIELD_W-1:0] point;
    } t_in;

    typedef struct packed {
        logic [OUT_W-1:0] cover_count;
        logic             saturated;
    } t_out;

    // Node memory port strobes
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_ram_ctl;

endpackage

`default_nettype wire

// File: rtl/interval_cover_count_tree.sv
// Interval cover counter. After reset a clearing pass zeroes the node memory
// and o_in_ready stays low. An add or remove request walks the tree bottom-up,
// one tree level at a time with at most one node read per cycle, with the
// read-modify-write overlapped; an empty range does not start a walk.
// A query reads one node per cycle from leaf to root. The single read port of
// the node memory sets this pace. Results wait in an output register so the
// next request can be taken meanwhile.
// Depends on icct_pkg, icct_ram, icct_seq.
`default_nettype none

module interval_cover_count_tree #(
    parameter int POSITIONS   = 1024,
    parameter int COUNT_WIDTH = 16
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    input  icct_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  wire             i_out_ready,
    output icct_pkg::t_out  o_out_data
);

    localparam int NODE_AW = $clog2(2*POSITIONS);

    icct_pkg::t_ram_ctl        ram_ctl;
    logic [NODE_AW-1:0]        ram_waddr, ram_raddr;
    logic [COUNT_WIDTH:0]      ram_wdata, ram_rdata;
    logic                      res_valid, res_ready;
    icct_pkg::t_out            res;

    icct_ram #(
        .DEPTH (2*POSITIONS),
        .WIDTH (COUNT_WIDTH+1)
    ) u_ram (
        .i_clk   (i_clk),
        .i_ctl   (ram_ctl),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    icct_seq #(
        .POSITIONS   (POSITIONS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in_valid),
        .o_req_ready (o_in_ready),
        .i_req       (i_in_data),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_ram_ctl   (ram_ctl),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    // Output register
    logic           r_out_vld, n_out_vld;
    icct_pkg::t_out r_out, n_out;

    assign res_ready = !r_out_vld || i_out_ready;

    always_comb begin
        n_out_vld = r_out_vld;
        n_out     = r_out;
        if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
        if (res_valid && res_ready) begin
            n_out_vld = 1'b1;
            n_out     = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// File: rtl/icct_ram.sv
// Node counter memory: one write port, one read port, registered read data.
// Depends on icct_pkg (port strobe struct).
`default_nettype none

module icct_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 17
) (
    input  wire                        i_clk,
    input  icct_pkg::t_ram_ctl         i_ctl,
    input  wire  [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire  [WIDTH-1:0]           i_wdata,
    input  wire  [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/icct_seq.sv
// Sequencer for the cover tree: clearing pass, range-update walk with
// read-modify-write, and root-ward query walk with a saturating sum.
// Depends on icct_pkg and interval_cover_count_tree_assert.svh.
`default_nettype none

module icct_seq #(
    parameter int POSITIONS   = 1024,
    parameter int COUNT_WIDTH = 16
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_req_valid,
    output logic                                  o_req_ready,
    input  icct_pkg::t_in                         i_req,
    output logic                                  o_res_valid,
    input  wire                                   i_res_ready,
    output icct_pkg::t_out                        o_res,
    output icct_pkg::t_ram_ctl                    o_ram_ctl,
    output logic [$clog2(2*POSITIONS)-1:0]        o_ram_waddr,
    output logic [COUNT_WIDTH:0]                  o_ram_wdata,
    output logic [$clog2(2*POSITIONS)-1:0]        o_ram_raddr,
    input  wire  [COUNT_WIDTH:0]                  i_ram_rdata
);

    localparam int NODE_AW = $clog2(2*POSITIONS);
    localparam int WALK_W  = $clog2(2*POSITIONS+1);
    localparam int SUM_W   = ((COUNT_WIDTH > icct_pkg::OUT_W) ? COUNT_WIDTH
                                                              : icct_pkg::OUT_W) + 1;
    localparam logic [NODE_AW-1:0] LAST_NODE = NODE_AW'(2*POSITIONS-1);
    localparam logic [NODE_AW-1:0] ROOT_NODE = NODE_AW'(1);

    // States
    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_WL   = 3'd2;
    localparam logic [2:0] ST_WR   = 3'd3;
    localparam logic [2:0] ST_QRD  = 3'd4;
    localparam logic [2:0] ST_QEND = 3'd5;
    localparam logic [2:0] ST_QOUT = 3'd6;

    logic [2:0]                    r_state, n_state;
    logic [NODE_AW-1:0]            r_clr_addr, n_clr_addr;
    logic [WALK_W-1:0]             r_left, n_left;
    logic [WALK_W-1:0]             r_right, n_right;
    logic                          r_raise, n_raise;
    logic                          r_pend, n_pend;
    logic [NODE_AW-1:0]            r_pend_addr, n_pend_addr;
    logic [NODE_AW-1:0]            r_node, n_node;
    logic                          r_qv, n_qv;
    logic [icct_pkg::OUT_W-1:0]    r_sum, n_sum;
    logic                          r_sat, n_sat;

    // Memory port strobes
    logic ram_rd, ram_wr;

    // Request decode, done at 32 bits since POSITIONS may be below the field range
    logic [31:0]        lo32, hi32, pt32, hi_clip;
    logic               upd_empty, pt_out;
    logic [WALK_W-1:0]  left_init, right_init;
    logic [NODE_AW-1:0] node_init;
    logic               accept;

    assign lo32      = 32'(i_req.range_low);
    assign hi32      = 32'(i_req.range_high);
    assign pt32      = 32'(i_req.point);
    assign upd_empty = (lo32 > hi32) || (lo32 >= 32'(POSITIONS));
    assign hi_clip   = (hi32 >= 32'(POSITIONS)) ? 32'(POSITIONS - 1) : hi32;
    assign left_init  = WALK_W'(lo32 + 32'(POSITIONS));
    assign right_init = WALK_W'(hi_clip + 32'(POSITIONS) + 32'd1);
    assign pt_out    = (pt32 >= 32'(POSITIONS));
    assign node_init = NODE_AW'(pt32 + 32'(POSITIONS));

    assign o_req_ready = (r_state == ST_IDLE) && !r_pend;
    assign accept      = i_req_valid && o_req_ready;

    // Read data split into counter and sticky clamp bit
    logic [COUNT_WIDTH-1:0] rd_count, wb_count;
    logic                   rd_clamp, wb_clamp;
    assign rd_count = i_ram_rdata[COUNT_WIDTH-1:0];
    assign rd_clamp = i_ram_rdata[COUNT_WIDTH];

    // Saturating bump of the counter read in the cycle before
    always_comb begin
        wb_count = rd_count;
        wb_clamp = rd_clamp;
        if (r_raise) begin
            if (rd_count == '1) begin
                wb_clamp = 1'b1;
            end else begin
                wb_count = rd_count + COUNT_WIDTH'(1);
            end
        end else begin
            if (rd_count == '0) begin
                wb_clamp = 1'b1;
            end else begin
                wb_count = rd_count - COUNT_WIDTH'(1);
            end
        end
    end

    // Saturating path sum
    logic [SUM_W-1:0]           acc_tmp;
    logic [icct_pkg::OUT_W-1:0] acc_sum;
    logic                       acc_sat;
    always_comb begin
        acc_tmp = SUM_W'(r_sum) + SUM_W'(rd_count);
        acc_sum = r_sum;
        acc_sat = r_sat;
        if (r_qv) begin
            acc_sat = r_sat | rd_clamp;
            if (acc_tmp > SUM_W'(icct_pkg::OUT_MAX)) begin
                acc_sum = icct_pkg::OUT_MAX;
                acc_sat = 1'b1;
            end else begin
                acc_sum = acc_tmp[icct_pkg::OUT_W-1:0];
            end
        end
    end

    // Memory write: clearing pass or update write-back
    always_comb begin
        ram_wr      = 1'b0;
        o_ram_waddr = r_pend_addr;
        o_ram_wdata = {wb_clamp, wb_count};
        if (r_state == ST_CLR) begin
            ram_wr      = 1'b1;
            o_ram_waddr = r_clr_addr;
            o_ram_wdata = '0;
        end else if (r_pend) begin
            ram_wr = 1'b1;
        end
    end

    assign o_ram_ctl = {ram_wr, ram_rd};

    // Main sequencer
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_left      = r_left;
        n_right     = r_right;
        n_raise     = r_raise;
        n_pend      = 1'b0;
        n_pend_addr = r_pend_addr;
        n_node      = r_node;
        n_qv        = 1'b0;
        n_sum       = acc_sum;
        n_sat       = acc_sat;
        ram_rd      = 1'b0;
        o_ram_raddr = r_node;
        o_res_valid = 1'b0;

        case (r_state)
            ST_CLR: begin
                n_clr_addr = r_clr_addr + NODE_AW'(1);
                if (r_clr_addr == LAST_NODE) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (i_req.operation)
                        icct_pkg::OP_ADD, icct_pkg::OP_REMOVE: begin
                            n_raise = (i_req.operation == icct_pkg::OP_ADD);
                            n_left  = left_init;
                            n_right = right_init;
                            if (!upd_empty) begin
                                n_state = ST_WL;
                            end
                        end
                        icct_pkg::OP_QUERY: begin
                            n_sum  = '0;
                            n_sat  = 1'b0;
                            n_node = node_init;
                            n_state = pt_out ? ST_QOUT : ST_QRD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // Left boundary of one tree level
            ST_WL: begin
                if (r_left < r_right) begin
                    if (r_left[0]) begin
                        ram_rd      = 1'b1;
                        o_ram_raddr = r_left[NODE_AW-1:0];
                        n_pend      = 1'b1;
                        n_pend_addr = r_left[NODE_AW-1:0];
                        n_left      = r_left + WALK_W'(1);
                    end
                    n_state = ST_WR;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            // Right boundary, then climb one level
            ST_WR: begin
                if (r_right[0]) begin
                    ram_rd      = 1'b1;
                    o_ram_raddr = NODE_AW'(r_right - WALK_W'(1));
                    n_pend      = 1'b1;
                    n_pend_addr = NODE_AW'(r_right - WALK_W'(1));
                end
                n_right = (r_right - WALK_W'(r_right[0])) >> 1;
                n_left  = r_left >> 1;
                n_state = ST_WL;
            end
            // Query: one node read per cycle from leaf to root
            ST_QRD: begin
                ram_rd      = 1'b1;
                o_ram_raddr = r_node;
                n_qv        = 1'b1;
                if (r_node == ROOT_NODE) begin
                    n_state = ST_QEND;
                end else begin
                    n_node = r_node >> 1;
                end
            end
            ST_QEND: begin
                n_state = ST_QOUT;
            end
            ST_QOUT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_res = {r_sum, r_sat};

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLR;
            r_clr_addr <= '0;
            r_pend     <= 1'b0;
            r_qv       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_pend     <= n_pend;
            r_qv       <= n_qv;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_left      <= n_left;
        r_right     <= n_right;
        r_raise     <= n_raise;
        r_pend_addr <= n_pend_addr;
        r_node      <= n_node;
        r_sum       <= n_sum;
        r_sat       <= n_sat;
    end

`include "interval_cover_count_tree_assert.svh"

    `ICCT_ASSERT_IMPL(a_no_read_in_clear, r_state == ST_CLR, !ram_rd, "read during clear")
    `ICCT_ASSERT_IMPL(a_rw_distinct, ram_rd && ram_wr, o_ram_raddr != o_ram_waddr, "rw same node")
    `ICCT_ASSERT_IMPL(a_pend_blocks_accept, r_pend, !o_req_ready, "accept in write-back")
    `ICCT_ASSERT_NEXT(a_query_no_writeback, r_state == ST_QRD, !r_pend, "write-back in query")

endmodule

`default_nettype wire
